### rtl/jwbs_pkg.sv
// shared types and constants of the jeroslow-wang branch selector
// used by jwbs_ctrl, jwbs_dp and jeroslow_wang_branch_select; no dependencies
`timescale 1ns / 1ps

package jwbs_pkg;

  localparam int unsigned SCORE_BITS = 48;
  localparam int unsigned VAR_BITS   = 10;
  localparam int unsigned SIZE_BITS  = 6;
  localparam int unsigned LIMIT_BITS = 11;

  localparam logic [1:0] OP_LIT = 2'd0;
  localparam logic [1:0] OP_ASG = 2'd1;
  localparam logic [1:0] OP_DEC = 2'd2;
  localparam logic [1:0] OP_CLR = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic scan_issue;
    logic lit_rd;
    logic lit_wr;
    logic asg_wr;
    logic clr_step;
    logic clr_asg;
    logic res_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic below_limit;
    logic pipe_busy;
    logic cnt_last;
  } sts_t;

endpackage

### rtl/jwbs_dp.sv
// datapath of the branch selector: score and assigned memories, item registers,
// scan pipeline, saturating adder and result register; depends on jwbs_pkg
`timescale 1ns / 1ps

module jwbs_dp #(
  parameter int MAX_VARS  = 1024,
  parameter int FRAC_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  jwbs_pkg::cmd_t                        cmd_i,
  output jwbs_pkg::sts_t                        sts_o,
  input  logic [jwbs_pkg::LIMIT_BITS-1:0]       var_limit_i,
  input  logic [jwbs_pkg::VAR_BITS-1:0]         vidx_i,
  input  logic                                  positive_i,
  input  logic [jwbs_pkg::SIZE_BITS-1:0]        csize_i,
  input  logic                                  assigned_i,
  output logic                                  found_o,
  output logic [jwbs_pkg::VAR_BITS-1:0]         pick_var_o,
  output logic                                  pick_pol_o,
  output logic [jwbs_pkg::SCORE_BITS-1:0]       best_score_o
);

  localparam int SB = jwbs_pkg::SCORE_BITS;
  localparam int VW = $clog2(MAX_VARS);
  localparam int CW = $clog2(MAX_VARS + 1);
  localparam int LW = (CW > jwbs_pkg::LIMIT_BITS) ? CW : jwbs_pkg::LIMIT_BITS;
  localparam logic [jwbs_pkg::SIZE_BITS-1:0] FracW = jwbs_pkg::SIZE_BITS'(FRAC_BITS);

  logic [2*SB-1:0] score_mem [MAX_VARS];
  logic            asg_mem   [MAX_VARS];

  // item registers
  logic [jwbs_pkg::VAR_BITS-1:0]  var_q;
  logic                           pos_q;
  logic [jwbs_pkg::SIZE_BITS-1:0] size_q;
  logic                           asg_q;

  logic [CW-1:0] cnt_q, cnt_d;

  // scan pipeline
  logic [2*SB-1:0] score_rd_q;
  logic            asg_rd_q;
  logic [VW-1:0]   idx1_q, idx2_q;
  logic            rd_v_q, c_v_q;
  logic [SB-1:0]   cand_q;
  logic            cand_val_q;
  logic            have_q;
  logic [SB-1:0]   best_q;
  logic [VW-1:0]   bidx_q;
  logic            bval_q;

  logic [LW-1:0]   var_ext, nv_ext, limit, best_ext;
  logic [VW-1:0]   var_addr, cnt_addr, rd_addr;
  logic            var_ok, lit_ok;
  logic [SB-1:0]   inc, old_score, new_score;
  logic [SB:0]     sum;
  logic [SB-1:0]   ps, ns;
  logic            score_we, asg_we, asg_wdata, rd_en;
  logic [VW-1:0]   score_waddr, asg_waddr;
  logic [2*SB-1:0] score_wdata;

  assign var_ext  = LW'(var_q);
  assign var_addr = var_ext[VW-1:0];
  assign cnt_addr = cnt_q[VW-1:0];
  assign var_ok   = var_ext < LW'(MAX_VARS);
  assign lit_ok   = var_ok && (size_q <= FracW);

  assign nv_ext = LW'(var_limit_i);
  assign limit  = (nv_ext > LW'(MAX_VARS)) ? LW'(MAX_VARS) : nv_ext;

  assign sts_o.below_limit = LW'(cnt_q) < limit;
  assign sts_o.pipe_busy   = rd_v_q | c_v_q;
  assign sts_o.cnt_last    = cnt_q == CW'(MAX_VARS - 1);

  // saturating add of 2^-size
  assign inc       = {{(SB-1){1'b0}}, 1'b1} << (FracW - size_q);
  assign old_score = pos_q ? score_rd_q[SB-1:0] : score_rd_q[2*SB-1:SB];
  assign sum       = {1'b0, old_score} + {1'b0, inc};
  assign new_score = sum[SB] ? {SB{1'b1}} : sum[SB-1:0];

  always_comb begin
    score_we    = 1'b0;
    score_waddr = cnt_addr;
    score_wdata = '0;
    if (cmd_i.clr_step) begin
      score_we = 1'b1;
    end else if (cmd_i.lit_wr && lit_ok) begin
      score_we    = 1'b1;
      score_waddr = var_addr;
      score_wdata = pos_q ? {score_rd_q[2*SB-1:SB], new_score}
                          : {new_score, score_rd_q[SB-1:0]};
    end
  end

  always_comb begin
    asg_we    = 1'b0;
    asg_waddr = cnt_addr;
    asg_wdata = 1'b0;
    if (cmd_i.clr_step && cmd_i.clr_asg) begin
      asg_we = 1'b1;
    end else if (cmd_i.asg_wr && var_ok) begin
      asg_we    = 1'b1;
      asg_waddr = var_addr;
      asg_wdata = asg_q;
    end else if (cmd_i.res_load && have_q) begin
      asg_we    = 1'b1;
      asg_waddr = bidx_q;
      asg_wdata = 1'b1;
    end
  end

  assign rd_en   = cmd_i.lit_rd | cmd_i.scan_issue;
  assign rd_addr = cmd_i.lit_rd ? var_addr : cnt_addr;

  always_ff @(posedge clk_i) begin
    if (score_we) begin
      score_mem[score_waddr] <= score_wdata;
    end
    if (rd_en) begin
      score_rd_q <= score_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (asg_we) begin
      asg_mem[asg_waddr] <= asg_wdata;
    end
    if (cmd_i.scan_issue) begin
      asg_rd_q <= asg_mem[cnt_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      var_q  <= vidx_i;
      pos_q  <= positive_i;
      size_q <= csize_i;
      asg_q  <= assigned_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.start) begin
      cnt_d = '0;
    end else if (cmd_i.scan_issue || cmd_i.clr_step) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  assign ps = score_rd_q[SB-1:0];
  assign ns = score_rd_q[2*SB-1:SB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rd_v_q <= 1'b0;
      c_v_q  <= 1'b0;
      have_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      rd_v_q <= cmd_i.scan_issue;
      c_v_q  <= rd_v_q && !asg_rd_q;
      if (cmd_i.start) begin
        have_q <= 1'b0;
      end else if (c_v_q && (!have_q || cand_q > best_q)) begin
        have_q <= 1'b1;
      end
    end
  end

  // best of one variable, positive wins a tie
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_issue) begin
      idx1_q <= cnt_addr;
    end
    if (rd_v_q) begin
      idx2_q     <= idx1_q;
      cand_q     <= (ns > ps) ? ns : ps;
      cand_val_q <= !(ns > ps);
    end
    if (c_v_q && (!have_q || cand_q > best_q)) begin
      best_q <= cand_q;
      bidx_q <= idx2_q;
      bval_q <= cand_val_q;
    end
  end

  assign best_ext = LW'(bidx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      found_o      <= have_q;
      pick_var_o   <= have_q ? best_ext[jwbs_pkg::VAR_BITS-1:0] : '0;
      pick_pol_o   <= have_q & bval_q;
      best_score_o <= have_q ? best_q : '0;
    end
  end

endmodule

### rtl/jwbs_ctrl.sv
// controller state machine of the branch selector: sequences clears,
// literal updates, assignments and decide scans; depends on jwbs_pkg
`timescale 1ns / 1ps

module jwbs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     op_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output jwbs_pkg::cmd_t cmd_o,
  input  jwbs_pkg::sts_t sts_i
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_LRD  = 3'd2;
  localparam logic [2:0] ST_LWR  = 3'd3;
  localparam logic [2:0] ST_ASG  = 3'd4;
  localparam logic [2:0] ST_DEC  = 3'd5;
  localparam logic [2:0] ST_DOUT = 3'd6;

  logic [2:0] state_q, state_d;
  logic       clr_asg_q, clr_asg_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d   = state_q;
    clr_asg_d = clr_asg_q;
    cmd_o     = '0;
    case (state_q)
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        cmd_o.clr_asg  = clr_asg_q;
        if (sts_i.cnt_last) begin
          state_d   = ST_IDLE;
          clr_asg_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load  = 1'b1;
          cmd_o.start = 1'b1;
          case (op_i)
            jwbs_pkg::OP_LIT: state_d = ST_LRD;
            jwbs_pkg::OP_ASG: state_d = ST_ASG;
            jwbs_pkg::OP_DEC: state_d = ST_DEC;
            default:          state_d = ST_CLR;
          endcase
        end
      end
      ST_LRD: begin
        cmd_o.lit_rd = 1'b1;
        state_d      = ST_LWR;
      end
      ST_LWR: begin
        cmd_o.lit_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_ASG: begin
        cmd_o.asg_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_DEC: begin
        cmd_o.scan_issue = sts_i.below_limit;
        if (!sts_i.below_limit && !sts_i.pipe_busy) begin
          state_d = ST_DOUT;
        end
      end
      ST_DOUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_asg_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_asg_q   <= clr_asg_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_res_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending beat");

  a_out_from_dout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DOUT))
    else $error("result beat raised outside result state");

  a_clr_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR && sts_i.cnt_last) |=> (state_q == ST_IDLE && !clr_asg_q))
    else $error("clear sweep did not finish");

  a_scan_in_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.pipe_busy |-> (state_q == ST_DEC))
    else $error("scan pipeline busy outside decide");
`endif

endmodule

### rtl/jeroslow_wang_branch_select.sv
// top level of the jeroslow-wang branch selector: stream ports, apb register
// and the jwbs_ctrl / jwbs_dp pair; depends on jwbs_pkg
`timescale 1ns / 1ps

// Each input beat carries one operation in s_axis_tuser: add a literal, set an
// assignment bit, decide, or clear all scores. A literal does one
// read-modify-write of the score memory and a clear writes one score row per
// cycle. A decide scans n = min(var limit, MAX_VARS) variable rows, one per
// cycle from the score memory, and loads its result only once no earlier result
// beat is still held at the output waiting for m_axis_tready. Only decide
// produces an output beat. After reset the block runs a clearing pass over both
// memories before it takes its first beat; the var limit register can be
// written at any time the block is idle.
module jeroslow_wang_branch_select #(
  parameter int MAX_VARS  = 1024,
  parameter int FRAC_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // var index, polarity, clause size, assigned
  input  logic [1:0]  s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // chosen var, chosen polarity, score
  output logic [0:0]  m_axis_tuser,  // found
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NVB = jwbs_pkg::LIMIT_BITS;
  localparam int SB  = jwbs_pkg::SCORE_BITS;
  localparam int VB  = jwbs_pkg::VAR_BITS;

  logic [NVB-1:0]       var_limit_q;
  jwbs_pkg::cmd_t       cmd;
  jwbs_pkg::sts_t       sts;
  logic                 found;
  logic [VB-1:0]        pick_var;
  logic                 pick_pol;
  logic [SB-1:0]        best_score;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(var_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_limit_q <= NVB'(1024);
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      var_limit_q <= pwdata[NVB-1:0];
    end
  end

  jwbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .op_i        (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  jwbs_dp #(
    .MAX_VARS  (MAX_VARS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .var_limit_i   (var_limit_q),
    .vidx_i        (s_axis_tdata[9:0]),
    .positive_i    (s_axis_tdata[10]),
    .csize_i       (s_axis_tdata[16:11]),
    .assigned_i    (s_axis_tdata[17]),
    .found_o       (found),
    .pick_var_o    (pick_var),
    .pick_pol_o    (pick_pol),
    .best_score_o  (best_score)
  );

  assign m_axis_tdata = {5'b0, best_score, pick_pol, pick_var};
  assign m_axis_tuser = found;

endmodule
